// ===== hdl/ohash_pkg.sv =====
// ----------------------------------------------------------------------------
// ohash_pkg
// Shared types and constants of the open-addressing hash table.
// ----------------------------------------------------------------------------
package ohash_pkg;

    localparam int KEY_BYTE_BITS = 8;
    localparam int KEY_BITS      = 2 * KEY_BYTE_BITS;
    localparam int HASH_MULT     = 33;
    localparam int HASH_MAX      = HASH_MULT * 255 + 255;
    localparam int HASH_W        = $clog2(HASH_MAX + 1);

    localparam int IN_VALUE_BITS = 32;
    localparam int OUT_VALUE_BITS = 32;
    localparam int SLOT_OUT_BITS = 8;
    localparam int STATUS_BITS   = 2;

    localparam int S_TDATA_W = 2 * KEY_BYTE_BITS + IN_VALUE_BITS;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = OUT_VALUE_BITS + SLOT_OUT_BITS;
    localparam int M_TUSER_W = STATUS_BITS;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic reduce;
        logic advance;
        logic finish_hit;
        logic finish_miss;
        logic clear_step;
    } ohash_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic red_done;
        logic hit;
        logic last_probe;
        logic clear_last;
    } ohash_stat_t;

endpackage

// ===== hdl/ohash_ram.sv =====
// ----------------------------------------------------------------------------
// ohash_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ohash_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ohash_ctrl.sv =====
// ----------------------------------------------------------------------------
// ohash_ctrl
// Controller: clearing pass, request intake, hash reduction, probe loop
// and the result register handshake.
// ----------------------------------------------------------------------------
module ohash_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  ohash_pkg::ohash_stat_t stat,
    output ohash_pkg::ohash_cmd_t  cmd
);
    import ohash_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_EVAL
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                cmd.reduce = 1'b1;
                if (stat.red_done) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                // A final answer waits here until the result register is free.
                if (stat.hit) begin
                    if (out_free) begin
                        cmd.finish_hit = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else if (stat.last_probe) begin
                    if (out_free) begin
                        cmd.finish_miss = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready_next = (state_next == S_IDLE);
        if (cmd.finish_hit || cmd.finish_miss) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== hdl/ohash_dp.sv =====
// ----------------------------------------------------------------------------
// ohash_dp
// Datapath: request registers, home slot reduction, probe position and
// step registers, table memories and the result register.
// ----------------------------------------------------------------------------
module ohash_dp #(
    parameter int TABLE_SLOTS = 256,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  ohash_pkg::ohash_cmd_t                  cmd,
    output ohash_pkg::ohash_stat_t                 stat,
    input  logic                                   in_command,
    input  logic [ohash_pkg::KEY_BYTE_BITS-1:0]    in_key_first,
    input  logic [ohash_pkg::KEY_BYTE_BITS-1:0]    in_key_second,
    input  logic [ohash_pkg::IN_VALUE_BITS-1:0]    in_value,
    output logic [ohash_pkg::STATUS_BITS-1:0]      out_status,
    output logic [ohash_pkg::OUT_VALUE_BITS-1:0]   out_value,
    output logic [ohash_pkg::SLOT_OUT_BITS-1:0]    out_slot
);
    import ohash_pkg::*;

    // Largest shift of the table size that still fits under the hash maximum.
    function automatic int red_top(input int n);
        int r;
        r = 0;
        for (int j = 0; j < HASH_W; j++) begin
            if ((n << j) <= HASH_MAX) begin
                r = j;
            end
        end
        return r;
    endfunction

    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int RED_TOP  = red_top(TABLE_SLOTS);
    localparam int RJ_W     = $clog2(RED_TOP + 1);
    localparam int DATA_W   = KEY_BITS + VALUE_BITS;
    localparam int SQ_INIT  = 1 % TABLE_SLOTS;
    localparam int D_INIT   = 3 % TABLE_SLOTS;
    localparam int D_INCR   = 2 % TABLE_SLOTS;

    function automatic logic [SLOT_W-1:0] mod_add(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (SLOT_W + 1)'(TABLE_SLOTS)) begin
            sum = sum - (SLOT_W + 1)'(TABLE_SLOTS);
        end
        return sum[SLOT_W-1:0];
    endfunction

    logic                   cmd_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [VALUE_BITS-1:0]  val_reg;
    logic [HASH_W-1:0]      rem_reg;
    logic [HASH_W-1:0]      rem_step;
    logic [HASH_W-1:0]      divisor;
    logic [RJ_W-1:0]        j_reg;
    logic [SLOT_W-1:0]      pos_reg;
    logic [SLOT_W-1:0]      sq_reg;
    logic [SLOT_W-1:0]      d_reg;
    logic [SLOT_W-1:0]      cnt_reg;
    logic [SLOT_W-1:0]      clr_reg;
    logic [STATUS_BITS-1:0]    status_reg;
    logic [OUT_VALUE_BITS-1:0] value_reg;
    logic [SLOT_OUT_BITS-1:0]  slot_reg;

    logic                   occ_rd;
    logic [DATA_W-1:0]      data_rd;
    logic                   occ_we;
    logic [SLOT_W-1:0]      occ_waddr;
    logic                   commit;
    logic                   is_insert;

    assign is_insert = (cmd_reg == CMD_INSERT);
    assign commit    = cmd.finish_hit && is_insert;

    // One restoring step of the home slot reduction per cycle.
    assign divisor  = HASH_W'(TABLE_SLOTS) << j_reg;
    assign rem_step = (rem_reg >= divisor) ? rem_reg - divisor : rem_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= in_command;
            key_reg <= {in_key_first, in_key_second};
            val_reg <= VALUE_BITS'(in_value);
            rem_reg <= HASH_W'(HASH_W'(in_key_first) * HASH_W'(HASH_MULT))
                       + HASH_W'(in_key_second);
            j_reg   <= RJ_W'(RED_TOP);
        end else if (cmd.reduce) begin
            rem_reg <= rem_step;
            j_reg   <= j_reg - RJ_W'(1);
        end
        if (cmd.reduce && stat.red_done) begin
            pos_reg <= rem_step[SLOT_W-1:0];
            sq_reg  <= SLOT_W'(SQ_INIT);
            d_reg   <= SLOT_W'(D_INIT);
            cnt_reg <= '0;
        end else if (cmd.advance) begin
            cnt_reg <= cnt_reg + SLOT_W'(1);
            if (is_insert) begin
                // Quadratic walk: sq holds step^2 and d holds 2*step+1, both mod size.
                pos_reg <= mod_add(pos_reg, sq_reg);
                sq_reg  <= mod_add(sq_reg, d_reg);
                d_reg   <= mod_add(d_reg, SLOT_W'(D_INCR));
            end else begin
                pos_reg <= mod_add(pos_reg, SLOT_W'(1));
            end
        end
        if (cmd.finish_hit) begin
            status_reg <= ST_OK;
            value_reg  <= is_insert ? '0 : OUT_VALUE_BITS'(data_rd[VALUE_BITS-1:0]);
            slot_reg   <= SLOT_OUT_BITS'(pos_reg);
        end else if (cmd.finish_miss) begin
            status_reg <= is_insert ? ST_FULL : ST_NOT_FOUND;
            value_reg  <= '0;
            slot_reg   <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_reg <= clr_reg + SLOT_W'(1);
        end
    end

    assign occ_we    = cmd.clear_step || commit;
    assign occ_waddr = cmd.clear_step ? clr_reg : pos_reg;

    ohash_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_SLOTS)
    ) u_occ_ram (
        .aclk  (aclk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (!cmd.clear_step),
        .raddr (pos_reg),
        .rdata (occ_rd)
    );

    ohash_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_SLOTS)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (commit),
        .waddr (pos_reg),
        .wdata ({key_reg, val_reg}),
        .raddr (pos_reg),
        .rdata (data_rd)
    );

    always_comb begin
        stat            = '0;
        stat.red_done   = (j_reg == '0);
        stat.last_probe = (cnt_reg == SLOT_W'(TABLE_SLOTS - 1));
        stat.clear_last = (clr_reg == SLOT_W'(TABLE_SLOTS - 1));
        if (is_insert) begin
            stat.hit = !occ_rd;
        end else begin
            stat.hit = occ_rd && (data_rd[DATA_W-1:VALUE_BITS] == key_reg);
        end
    end

    assign out_status = status_reg;
    assign out_value  = value_reg;
    assign out_slot   = slot_reg;

endmodule

// ===== hdl/open_addressing_hash_table.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Open-addressing hash table keyed by two-byte codes with a value word per
// entry. The home slot is (33*key_first + key_second) mod TABLE_SLOTS. An
// insert walks a quadratic path (steps 1, 4, 9, ...) to the first free slot
// and answers table full after TABLE_SLOTS probes; a lookup walks linearly
// once around the table and answers with the first matching entry. After
// reset the block clears every slot of the occupancy memory and takes no
// request meanwhile. A request is then taken in, the restoring reduction
// forms its home slot, and each probed slot is read from the table memory
// through its registered read port and then evaluated. The last probe is
// held while the previous answer still sits unaccepted in the result
// register. Only one request is in work at a time; the result register
// lets the next request be taken in while a result still waits on the
// output.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
    parameter int TABLE_SLOTS = 256,
    parameter int VALUE_BITS  = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key_first [7:0], key_second [15:8], value_in [47:16]
    input  logic [ohash_pkg::S_TDATA_W-1:0] s_tdata,
    // command [0]
    input  logic [ohash_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // value_out [31:0], slot [39:32]
    output logic [ohash_pkg::M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [ohash_pkg::M_TUSER_W-1:0] m_tuser
);
    import ohash_pkg::*;

    ohash_cmd_t                cmd;
    ohash_stat_t               stat;
    logic [STATUS_BITS-1:0]    out_status;
    logic [OUT_VALUE_BITS-1:0] out_value;
    logic [SLOT_OUT_BITS-1:0]  out_slot;

    ohash_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ohash_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_command    (s_tuser[0]),
        .in_key_first  (s_tdata[KEY_BYTE_BITS-1:0]),
        .in_key_second (s_tdata[2*KEY_BYTE_BITS-1:KEY_BYTE_BITS]),
        .in_value      (s_tdata[S_TDATA_W-1:2*KEY_BYTE_BITS]),
        .out_status    (out_status),
        .out_value     (out_value),
        .out_slot      (out_slot)
    );

    assign m_tdata = {out_slot, out_value};
    assign m_tuser = out_status;

`ifndef SYNTH
    // Only one request is in work: taking one drops ready on the next cycle.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in work");

    // A failed request reports a zero slot and a zero value.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
        else $error("failed result carries a slot or value");

    // The result register is only loaded when it is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(cmd.finish_hit || cmd.finish_miss))
        else $error("result overwritten while stalled");

    // The clearing pass never overlaps a probe.
    a_clear_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !(cmd.load || cmd.advance || cmd.finish_hit))
        else $error("clearing pass overlaps a request");
`endif

endmodule

// ===== bench/open_addressing_hash_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_tb
// Stream-level bench for the open-addressing hash table. A short table of
// requests covers empty-table lookups, extreme keys and values, home-slot
// collisions, duplicate keys and the wrap at the top slot. RANDOM_COUNT random
// inserts and lookups follow, mostly inserts, so the table runs full. Each
// answer is checked against a fixed answer or a behavioral table copy.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_tb;
    import ohash_pkg::*;

    localparam int SLOTS        = 256;
    localparam int RANDOM_COUNT = 400;

    typedef struct packed {
        logic [STATUS_BITS-1:0]    status;
        logic [OUT_VALUE_BITS-1:0] value;
        logic [SLOT_OUT_BITS-1:0]  slot;
    } answer_t;

    typedef struct {
        logic        cmd;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [31:0] value;
        bit          fixed;
        answer_t     answer;
    } request_row_t;

    typedef enum int {RX_OPEN, RX_MASK, RX_SPARSE} rx_mode_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    // Behavioral copy of the table.
    bit          slot_used [SLOTS];
    logic [15:0] slot_key  [SLOTS];
    logic [31:0] slot_val  [SLOTS];

    answer_t      pending_answers [$];
    request_row_t directed_rows [$];
    logic [15:0]  stored_keys [$];

    int error_count = 0;
    int n_insert = 0, n_lookup = 0, n_hit = 0, n_absent = 0, n_full = 0;
    int n_answers = 0;
    int burst_left = 0;

    open_addressing_hash_table #(
        .TABLE_SLOTS (SLOTS),
        .VALUE_BITS  (32)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d answers outstanding", pending_answers.size());
        $display("[open_addressing_hash_table] ERROR");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Applies one request to the table copy and returns the answer it should give.
    function automatic answer_t table_apply(input logic cmd, input logic [7:0] first,
                                            input logic [7:0] second,
                                            input logic [31:0] value);
        answer_t    ans;
        logic [15:0] key;
        int          pos;
        int          step;
        key = {first, second};
        pos = (HASH_MULT * int'(first) + int'(second)) % SLOTS;
        ans = '0;
        if (cmd == CMD_INSERT) begin
            n_insert++;
            ans.status = ST_FULL;
            step = 1;
            for (int n = 0; n < SLOTS; n++) begin
                if (!slot_used[pos]) begin
                    slot_used[pos] = 1'b1;
                    slot_key[pos]  = key;
                    slot_val[pos]  = value;
                    ans.status     = ST_OK;
                    ans.slot       = pos[7:0];
                    break;
                end
                pos = (pos + step * step) % SLOTS;
                step++;
            end
            if (ans.status == ST_FULL) begin
                n_full++;
            end
        end else begin
            n_lookup++;
            ans.status = ST_NOT_FOUND;
            for (int n = 0; n < SLOTS; n++) begin
                if (slot_used[pos] && slot_key[pos] == key) begin
                    ans.status = ST_OK;
                    ans.value  = slot_val[pos];
                    ans.slot   = pos[7:0];
                    break;
                end
                pos = (pos + 1) % SLOTS;
            end
            if (ans.status == ST_OK) begin
                n_hit++;
            end else begin
                n_absent++;
            end
        end
        return ans;
    endfunction

    task automatic add_row(input logic cmd, input logic [7:0] first,
                           input logic [7:0] second, input logic [31:0] value,
                           input bit fixed, input logic [1:0] status,
                           input logic [31:0] value_out, input logic [7:0] slot);
        request_row_t row;
        row.cmd    = cmd;
        row.first  = first;
        row.second = second;
        row.value  = value;
        row.fixed  = fixed;
        row.answer = '{status: status, value: value_out, slot: slot};
        directed_rows.push_back(row);
    endtask

    // Presents one request in bursts with random gaps, waits for it to be taken
    // and records the answer it should produce.
    task automatic send_request(input logic cmd, input logic [7:0] first,
                                input logic [7:0] second, input logic [31:0] value,
                                input bit fixed, input answer_t fixed_answer);
        int      gap;
        answer_t ans;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {value, second, first};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        ans = table_apply(cmd, first, second, value);
        pending_answers.push_back(fixed ? fixed_answer : ans);
        if (cmd == CMD_INSERT) begin
            stored_keys.push_back({first, second});
        end
    endtask

    task automatic drain_answers;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        wait (pending_answers.size() == 0);
    endtask

    // Receiver stalls: open stretches, a repeating mask, or sparse readiness.
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic [15:0] rx_mask = '1;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(16, 96);
            rx_mask = 16'($urandom);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_OPEN: begin
                m_tready <= 1'b1;
            end
            RX_MASK: begin
                m_tready <= rx_mask[rx_left % 16];
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_answers++;
            if (pending_answers.size() == 0) begin
                note_mismatch($sformatf("answer with nothing pending: status %0d slot %0d",
                                        m_tuser, m_tdata[39:32]));
            end else begin
                want = pending_answers.pop_front();
                if (m_tuser != want.status) begin
                    note_mismatch($sformatf("answer %0d status %0d, want %0d",
                                            n_answers, m_tuser, want.status));
                end
                if (m_tdata[31:0] != want.value) begin
                    note_mismatch($sformatf("answer %0d value %h, want %h",
                                            n_answers, m_tdata[31:0], want.value));
                end
                if (m_tdata[39:32] != want.slot) begin
                    note_mismatch($sformatf("answer %0d slot %0d, want %0d",
                                            n_answers, m_tdata[39:32], want.slot));
                end
            end
        end
    end

    initial begin
        request_row_t row;
        logic         cmd;
        logic [7:0]   first;
        logic [7:0]   second;
        logic [31:0]  value;
        logic [15:0]  key;
        int           pick;

        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
        end

        // Empty table, extreme keys and values, then collisions and duplicates.
        add_row(CMD_LOOKUP, 8'd0,   8'd0,   32'h0000_0000, 1, ST_NOT_FOUND, '0, '0);
        add_row(CMD_LOOKUP, 8'd255, 8'd255, 32'hFFFF_FFFF, 1, ST_NOT_FOUND, '0, '0);
        add_row(CMD_INSERT, 8'd0,   8'd0,   32'h0000_0000, 1, ST_OK, '0, 8'd0);
        add_row(CMD_INSERT, 8'd255, 8'd255, 32'hFFFF_FFFF, 1, ST_OK, '0, 8'd222);
        add_row(CMD_LOOKUP, 8'd255, 8'd255, 32'h0000_0000, 1, ST_OK, 32'hFFFF_FFFF, 8'd222);
        add_row(CMD_LOOKUP, 8'd0,   8'd0,   32'hFFFF_FFFF, 1, ST_OK, '0, 8'd0);
        add_row(CMD_INSERT, 8'd1,   8'd0,   32'hA5A5_A5A5, 1, ST_OK, '0, 8'd33);
        // Same home slot as the key above.
        add_row(CMD_INSERT, 8'd0,   8'd33,  32'h5A5A_5A5A, 0, '0, '0, '0);
        add_row(CMD_LOOKUP, 8'd0,   8'd33,  32'h0000_0000, 0, '0, '0, '0);
        add_row(CMD_LOOKUP, 8'd1,   8'd0,   32'h0000_0000, 0, '0, '0, '0);
        add_row(CMD_INSERT, 8'd0,   8'd0,   32'h1234_5678, 0, '0, '0, '0);
        add_row(CMD_LOOKUP, 8'd0,   8'd0,   32'h0000_0000, 0, '0, '0, '0);
        // The top slot, then two more copies that must wrap around.
        add_row(CMD_INSERT, 8'd7,   8'd24,  32'h0F0F_0F0F, 1, ST_OK, '0, 8'd255);
        add_row(CMD_INSERT, 8'd7,   8'd24,  32'hF0F0_F0F0, 0, '0, '0, '0);
        add_row(CMD_INSERT, 8'd7,   8'd24,  32'h0000_0001, 0, '0, '0, '0);
        add_row(CMD_LOOKUP, 8'd7,   8'd24,  32'h0000_0000, 0, '0, '0, '0);
        add_row(CMD_LOOKUP, 8'd0,   8'd255, 32'h0000_0000, 1, ST_NOT_FOUND, '0, '0);
        add_row(CMD_LOOKUP, 8'd128, 8'd1,   32'hFFFF_FFFF, 1, ST_NOT_FOUND, '0, '0);
        add_row(CMD_INSERT, 8'd128, 8'd128, 32'h8000_0000, 0, '0, '0, '0);
        add_row(CMD_LOOKUP, 8'd128, 8'd128, 32'h0000_0000, 0, '0, '0, '0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.cmd, row.first, row.second, row.value, row.fixed, row.answer);
        end
        drain_answers();

        // Insert-heavy mix, so the table fills and later inserts run out of room.
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            cmd    = ($urandom_range(0, 99) < 68) ? CMD_INSERT : CMD_LOOKUP;
            first  = 8'($urandom);
            second = 8'($urandom);
            pick   = $urandom_range(0, 9);
            if (stored_keys.size() > 0 && ((cmd == CMD_LOOKUP && pick < 6) || pick < 2)) begin
                key    = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                first  = key[15:8];
                second = key[7:0];
            end else if (pick == 9) begin
                first  = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
                second = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            end
            case ($urandom_range(0, 7))
                0:       value = 32'h0000_0000;
                1:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            send_request(cmd, first, second, value, 0, '0);
            if (i == RANDOM_COUNT / 2 || $urandom_range(0, 49) == 0) begin
                drain_answers();
            end
        end

        drain_answers();
        repeat (100) @(posedge aclk);

        $display("covered %0d inserts (%0d refused as full) and %0d lookups", n_insert,
                 n_full, n_lookup);
        $display("lookups: %0d found, %0d absent; %0d answers checked", n_hit, n_absent,
                 n_answers);
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("[open_addressing_hash_table] OK");
        end else begin
            if (pending_answers.size() != 0) begin
                note_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));
            end
            $display("[open_addressing_hash_table] ERROR");
        end
        $finish;
    end

endmodule
